// ===== rtl/hrof_pkg.sv =====
// shared types and constants for the heart rate output filter
package hrof_pkg;

   localparam int RATE_W   = 8;
   localparam int CFG_W    = 8;
   localparam int STATUS_W = 2;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SIGNAL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE     = 2'd2;

   typedef enum logic [2:0] {
      CSR_SMALL_DELTA  = 3'd0,
      CSR_MATCH_DELTA  = 3'd1,
      CSR_SPIKE_DELTA  = 3'd2,
      CSR_START_CONF   = 3'd3,
      CSR_MEDIUM_CONF  = 3'd4,
      CSR_SPIKE_CONF   = 3'd5,
      CSR_HOLD_TICKS   = 3'd6,
      CSR_STEP_CAP     = 3'd7
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE  = 1'b0,
      OP_MISSING = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [RATE_W-1:0]  rate;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_stat_type;

   typedef struct packed {
      logic [CFG_W-1:0] small_delta;
      logic [CFG_W-1:0] match_delta;
      logic [CFG_W-1:0] spike_delta;
      logic [CFG_W-1:0] start_confirm;
      logic [CFG_W-1:0] medium_confirm;
      logic [CFG_W-1:0] spike_confirm;
      logic [CFG_W-1:0] hold_ticks;
      logic [CFG_W-1:0] step_cap;
   } cfg_type;

endpackage

// ===== rtl/hrof_front.sv =====
// input stage: accepts words, tags them sample or missing, pushes into the queue
module hrof_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_raw_valid,
   input  logic [hrof_pkg::RATE_W-1:0] req_raw_rate,
   input  hrof_pkg::q_stat_type       q_stat,
   output logic                       push,
   output hrof_pkg::item_type         push_item
);

   logic               valid_ff, valid_in;
   hrof_pkg::item_type item_ff, item_in;
   logic               load;

   assign push      = valid_ff && !q_stat.full;
   assign load      = !valid_ff || push;
   assign req_stall = !load;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in     = req_valid;
         item_in.op   = req_raw_valid ? hrof_pkg::OP_SAMPLE : hrof_pkg::OP_MISSING;
         item_in.rate = req_raw_rate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// ===== rtl/hrof_queue.sv =====
// short fifo between the input stage and the filter stage
module hrof_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  hrof_pkg::item_type   push_item,
   input  logic                 pop,
   output hrof_pkg::item_type   head_item,
   output hrof_pkg::q_stat_type q_stat
);

   hrof_pkg::item_type                 mem_ff [hrof_pkg::Q_DEPTH];
   logic [hrof_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hrof_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hrof_pkg::Q_CNT_W-1:0]       count_ff, count_in;

   assign q_stat.full      = (count_ff == hrof_pkg::Q_CNT_W'(hrof_pkg::Q_DEPTH));
   assign q_stat.not_empty = (count_ff != '0);
   assign head_item        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + hrof_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + hrof_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + hrof_pkg::Q_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - hrof_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_stat.full || pop))
      else $error("push into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.not_empty)
      else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hrof_pkg::Q_CNT_W'(hrof_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== rtl/hrof_back.sv =====
// filter stage: prefilter, lock and confirm logic, step limit, result register
module hrof_back (
   input  logic                          clock,
   input  logic                          reset,
   input  hrof_pkg::cfg_type             cfg,
   input  hrof_pkg::q_stat_type          q_stat,
   input  hrof_pkg::item_type            head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hrof_pkg::RATE_W-1:0]   rsp_rate_out,
   output logic                          rsp_rate_locked,
   output logic [hrof_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_cleared
);

   localparam int W = hrof_pkg::RATE_W;
   localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

   function automatic logic [W-1:0] dist8(input logic [W-1:0] a, input logic [W-1:0] b);
      dist8 = (a >= b) ? a - b : b - a;
   endfunction

   function automatic logic [W-1:0] avg2(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s    = {1'b0, a} + {1'b0, b} + (W+1)'(1);
      avg2 = s[W:1];
   endfunction

   function automatic logic [W-1:0] mid3(input logic [W-1:0] a, input logic [W-1:0] b,
                                         input logic [W-1:0] c);
      logic [W-1:0] lo;
      logic [W-1:0] hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (c <= lo) begin
         mid3 = lo;
      end else if (c >= hi) begin
         mid3 = hi;
      end else begin
         mid3 = c;
      end
   endfunction

   function automatic logic [W-1:0] step_limit(input logic [W-1:0] cur,
                                               input logic [W-1:0] tgt,
                                               input logic [W-1:0] lim);
      if (tgt > cur && (tgt - cur) > lim) begin
         step_limit = cur + lim;
      end else if (cur > tgt && (cur - tgt) > lim) begin
         step_limit = cur - lim;
      end else begin
         step_limit = tgt;
      end
   endfunction

   logic [W-1:0] hist_ff [3];
   logic [W-1:0] hist_in [3];
   logic [1:0]   fill_ff, fill_in;
   logic [1:0]   pos_ff, pos_in;
   logic [W-1:0] cand_ff, cand_in;
   logic [W-1:0] count_ff, count_in;
   logic [W-1:0] invalid_ff, invalid_in;
   logic [W-1:0] value_ff, value_in;
   logic         locked_ff, locked_in;
   logic [hrof_pkg::STATUS_W-1:0] status_ff, status_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_rate_ff;
   logic         rsp_locked_ff;
   logic [hrof_pkg::STATUS_W-1:0] rsp_status_ff;
   logic         rsp_cleared_ff, rsp_cleared_in;

   assign pop          = q_stat.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      logic [1:0]   p;
      logic [W-1:0] f;
      logic [W-1:0] d;
      logic [W-1:0] need;
      logic [W-1:0] tgt;
      logic         spike;
      logic         take;
      logic [W+1:0] quarter;
      logic [W+2:0] blend;

      hist_in        = hist_ff;
      fill_in        = fill_ff;
      pos_in         = pos_ff;
      cand_in        = cand_ff;
      count_in       = count_ff;
      invalid_in     = invalid_ff;
      value_in       = value_ff;
      locked_in      = locked_ff;
      status_in      = status_ff;
      rsp_cleared_in = 1'b0;
      p              = (pos_ff == 2'd3) ? 2'd0 : pos_ff;
      f              = '0;
      d              = '0;
      need           = '0;
      tgt            = '0;
      spike          = 1'b0;
      take           = 1'b0;
      quarter        = '0;
      blend          = '0;

      if (head_item.op == hrof_pkg::OP_SAMPLE) begin
         hist_in[p] = head_item.rate;
         pos_in     = (p == 2'd2) ? 2'd0 : p + 2'd1;
         if (fill_ff != 2'd3) begin
            fill_in = fill_ff + 2'd1;
         end
         case (fill_in)
            2'd1:    f = hist_in[0];
            2'd2:    f = avg2(hist_in[0], hist_in[1]);
            default: f = mid3(hist_in[0], hist_in[1], hist_in[2]);
         endcase
         invalid_in = '0;

         if (!locked_ff) begin
            if (count_ff == '0 || dist8(f, cand_ff) > cfg.small_delta) begin
               cand_in  = f;
               count_in = W'(1);
            end else begin
               count_in = (count_ff != CNT_MAX) ? count_ff + W'(1) : count_ff;
               cand_in  = avg2(cand_ff, f);
            end
            if (count_in >= cfg.start_confirm) begin
               locked_in = 1'b1;
               value_in  = cand_in;
               status_in = hrof_pkg::STATUS_OK;
               count_in  = '0;
            end
         end else begin
            d = dist8(f, value_ff);
            if (d <= cfg.small_delta) begin
               quarter = {1'b0, value_ff, 1'b0} + {2'b00, value_ff} + {2'b00, f}
                       + (W+2)'(2);
               tgt     = quarter[W+1:2];
               take    = 1'b1;
            end else begin
               spike = d > cfg.spike_delta;
               need  = spike ? cfg.spike_confirm : cfg.medium_confirm;
               if (count_ff == '0 || dist8(f, cand_ff) > cfg.match_delta) begin
                  cand_in  = f;
                  count_in = W'(1);
               end else begin
                  count_in = (count_ff != CNT_MAX) ? count_ff + W'(1) : count_ff;
                  cand_in  = avg2(cand_ff, f);
                  if (count_in >= need) begin
                     blend = {1'b0, value_ff, 2'b00} + {3'b000, value_ff}
                           + {2'b00, cand_in, 1'b0} + {3'b000, cand_in} + (W+3)'(4);
                     tgt   = spike ? blend[W+2:3] : avg2(value_ff, cand_in);
                     take  = 1'b1;
                  end
               end
            end
            if (take) begin
               value_in  = step_limit(value_ff, tgt, cfg.step_cap);
               status_in = hrof_pkg::STATUS_OK;
               cand_in   = value_in;
               count_in  = '0;
            end
         end
      end else begin
         if (locked_ff && invalid_ff < cfg.hold_ticks) begin
            invalid_in = invalid_ff + W'(1);
         end else begin
            fill_in        = '0;
            pos_in         = '0;
            cand_in        = '0;
            count_in       = '0;
            invalid_in     = '0;
            value_in       = '0;
            locked_in      = 1'b0;
            status_in      = hrof_pkg::STATUS_STALE;
            rsp_cleared_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         pos_ff       <= '0;
         cand_ff      <= '0;
         count_ff     <= '0;
         invalid_ff   <= '0;
         value_ff     <= '0;
         locked_ff    <= 1'b0;
         status_ff    <= hrof_pkg::STATUS_NO_SIGNAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            fill_ff    <= fill_in;
            pos_ff     <= pos_in;
            cand_ff    <= cand_in;
            count_ff   <= count_in;
            invalid_ff <= invalid_in;
            value_ff   <= value_in;
            locked_ff  <= locked_in;
            status_ff  <= status_in;
         end
      end
      if (pop) begin
         hist_ff        <= hist_in;
         rsp_rate_ff    <= value_in;
         rsp_locked_ff  <= locked_in;
         rsp_status_ff  <= status_in;
         rsp_cleared_ff <= rsp_cleared_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rate_out    = rsp_rate_ff;
   assign rsp_rate_locked = rsp_locked_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_cleared     = rsp_cleared_ff;

   a_locked_ok: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> (status_ff == hrof_pkg::STATUS_OK))
      else $error("locked filter with non-ok status");
   a_unlocked_zero: assert property (@(posedge clock) disable iff (reset)
      !locked_ff |-> (value_ff == '0))
      else $error("unlocked filter holds a value");
   a_clear_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cleared_ff) |->
         (!rsp_locked_ff && rsp_rate_ff == '0 && rsp_status_ff == hrof_pkg::STATUS_STALE))
      else $error("clear word carries stale state");
   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped word not presented");

endmodule

// ===== rtl/heart_rate_output_filter_core.sv =====
// heart rate output filter top level: config registers, input stage, queue, filter stage
// path: an accepted word passes the input register, the queue and the result register before it is presented on rsp
// throughput: one word per cycle while neither side stalls; the filter stage updates all its state together on each pop
// a four-word queue lets the input side keep accepting while the result side stalls, until the queue is full
// reset: synchronous, clears the filter state, status reads no signal, registers take defaults
module heart_rate_output_filter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_raw_valid,
   input  logic [hrof_pkg::RATE_W-1:0]   req_raw_rate,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hrof_pkg::RATE_W-1:0]   rsp_rate_out,
   output logic                          rsp_rate_locked,
   output logic [hrof_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_cleared,
   input  logic                          csr_write,
   input  logic [2:0]                    csr_index,
   input  logic [hrof_pkg::CFG_W-1:0]    csr_wdata
);

   hrof_pkg::cfg_type    cfg_ff, cfg_in;
   hrof_pkg::q_stat_type q_stat;
   hrof_pkg::item_type   push_item;
   hrof_pkg::item_type   head_item;
   logic                 push;
   logic                 pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (hrof_pkg::csr_index_type'(csr_index))
            hrof_pkg::CSR_SMALL_DELTA: cfg_in.small_delta    = csr_wdata;
            hrof_pkg::CSR_MATCH_DELTA: cfg_in.match_delta    = csr_wdata;
            hrof_pkg::CSR_SPIKE_DELTA: cfg_in.spike_delta    = csr_wdata;
            hrof_pkg::CSR_START_CONF:  cfg_in.start_confirm  = csr_wdata;
            hrof_pkg::CSR_MEDIUM_CONF: cfg_in.medium_confirm = csr_wdata;
            hrof_pkg::CSR_SPIKE_CONF:  cfg_in.spike_confirm  = csr_wdata;
            hrof_pkg::CSR_HOLD_TICKS:  cfg_in.hold_ticks     = csr_wdata;
            hrof_pkg::CSR_STEP_CAP:    cfg_in.step_cap       = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_delta    <= 8'd10;
         cfg_ff.match_delta    <= 8'd18;
         cfg_ff.spike_delta    <= 8'd32;
         cfg_ff.start_confirm  <= 8'd2;
         cfg_ff.medium_confirm <= 8'd2;
         cfg_ff.spike_confirm  <= 8'd3;
         cfg_ff.hold_ticks     <= 8'd100;
         cfg_ff.step_cap       <= 8'd12;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hrof_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_valid (req_raw_valid),
      .req_raw_rate  (req_raw_rate),
      .q_stat        (q_stat),
      .push          (push),
      .push_item     (push_item)
   );

   hrof_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_stat    (q_stat)
   );

   hrof_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_stat          (q_stat),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rate_out    (rsp_rate_out),
      .rsp_rate_locked (rsp_rate_locked),
      .rsp_status      (rsp_status),
      .rsp_cleared     (rsp_cleared)
   );

endmodule

// ===== bench/heart_rate_output_filter_core_test.sv =====
// self-checking bench for heart_rate_output_filter_core with directed table and random phases
`timescale 1ns / 100ps

module heart_rate_output_filter_core_test;

   typedef struct packed {
      logic [hrof_pkg::RATE_W-1:0]   rate;
      logic                          locked;
      logic [hrof_pkg::STATUS_W-1:0] status;
      logic                          cleared;
   } rate_word_type;

   typedef struct packed {
      logic                        vld;
      logic [hrof_pkg::RATE_W-1:0] raw;
      logic                        known;
      rate_word_type               want;
   } dir_row_type;

   typedef enum {RUN_STEADY, RUN_JUMP, RUN_DROP, RUN_NOISE} run_kind_type;

   localparam int QUIET_LIMIT   = 500;
   localparam int FIXED_PHASES  = 6;
   localparam int RANDOM_PHASES = 3;
   localparam int DIR_COUNT     = 21;

   localparam hrof_pkg::cfg_type CFG_DEFAULTS =
      {8'd10, 8'd18, 8'd32, 8'd2, 8'd2, 8'd3, 8'd100, 8'd12};

   // small, match, spike, start, medium, spike confirm, hold, step
   localparam hrof_pkg::cfg_type PHASE_CFG [FIXED_PHASES] = '{
      {8'd10,  8'd18,  8'd32,  8'd2,   8'd2,   8'd3,   8'd0,   8'd12},
      {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
      {8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
      {8'd40,  8'd10,  8'd20,  8'd3,   8'd1,   8'd2,   8'd5,   8'd30},
      {8'd2,   8'd4,   8'd8,   8'd1,   8'd3,   8'd5,   8'd3,   8'd4},
      CFG_DEFAULTS
   };
   localparam int PHASE_LEN [FIXED_PHASES]   = '{200, 320, 150, 200, 200, 150};
   localparam bit PHASE_CLEAN [FIXED_PHASES] = '{0, 1, 0, 0, 0, 0};

   // first two rows start from reset state: one candidate, then first lock
   localparam dir_row_type DIR_ROWS [DIR_COUNT] = '{
      {1'b1, 8'd100, 1'b1, 8'd0,   1'b0, hrof_pkg::STATUS_NO_SIGNAL, 1'b0},
      {1'b1, 8'd100, 1'b1, 8'd100, 1'b1, hrof_pkg::STATUS_OK,        1'b0},
      {1'b1, 8'd104, 1'b0, 12'd0},
      {1'b1, 8'd112, 1'b0, 12'd0},
      {1'b1, 8'd130, 1'b0, 12'd0},
      {1'b1, 8'd132, 1'b0, 12'd0},
      {1'b1, 8'd128, 1'b0, 12'd0},
      {1'b1, 8'd200, 1'b0, 12'd0},
      {1'b1, 8'd210, 1'b0, 12'd0},
      {1'b1, 8'd205, 1'b0, 12'd0},
      {1'b1, 8'd255, 1'b0, 12'd0},
      {1'b1, 8'd255, 1'b0, 12'd0},
      {1'b1, 8'd0,   1'b0, 12'd0},
      {1'b1, 8'd0,   1'b0, 12'd0},
      {1'b1, 8'd0,   1'b0, 12'd0},
      {1'b0, 8'd255, 1'b0, 12'd0},
      {1'b0, 8'd0,   1'b0, 12'd0},
      {1'b0, 8'd170, 1'b0, 12'd0},
      {1'b1, 8'd90,  1'b0, 12'd0},
      {1'b1, 8'd85,  1'b0, 12'd0},
      {1'b1, 8'd88,  1'b0, 12'd0}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_raw_valid;
   logic [hrof_pkg::RATE_W-1:0]   req_raw_rate;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [hrof_pkg::RATE_W-1:0]   rsp_rate_out;
   logic                          rsp_rate_locked;
   logic [hrof_pkg::STATUS_W-1:0] rsp_status;
   logic                          rsp_cleared;
   logic                          csr_write;
   logic [2:0]                    csr_index;
   logic [hrof_pkg::CFG_W-1:0]    csr_wdata;

   heart_rate_output_filter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_valid   (req_raw_valid),
      .req_raw_rate    (req_raw_rate),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rate_out    (rsp_rate_out),
      .rsp_rate_locked (rsp_rate_locked),
      .rsp_status      (rsp_status),
      .rsp_cleared     (rsp_cleared),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // filter state mirror
   hrof_pkg::cfg_type             cfg = CFG_DEFAULTS;
   logic [hrof_pkg::RATE_W-1:0]   hist [3] = '{8'd0, 8'd0, 8'd0};
   logic [1:0]                    hist_fill = '0;
   logic [1:0]                    hist_pos = '0;
   logic [hrof_pkg::RATE_W-1:0]   cand_rate = '0;
   logic [7:0]                    cand_cnt = '0;
   logic [7:0]                    miss_cnt = '0;
   logic [hrof_pkg::RATE_W-1:0]   shown_rate = '0;
   logic                          is_locked = 1'b0;
   logic [hrof_pkg::STATUS_W-1:0] cur_status = hrof_pkg::STATUS_NO_SIGNAL;

   rate_word_type rate_words [$];
   bit            calm = 1'b0;
   int            fail_count = 0;
   int            items_sent = 0;
   int            words_checked = 0;
   int            clear_words = 0;
   int            locked_words = 0;
   int            quiet_cycles = 0;

   function automatic logic [hrof_pkg::RATE_W-1:0] rate_gap(
      input logic [hrof_pkg::RATE_W-1:0] a, b);
      return a >= b ? a - b : b - a;
   endfunction

   function automatic logic [hrof_pkg::RATE_W-1:0] limit_step(
      input logic [hrof_pkg::RATE_W-1:0] cur, tgt, lim);
      if (tgt > cur && tgt - cur > lim) return cur + lim;
      if (cur > tgt && cur - tgt > lim) return cur - lim;
      return tgt;
   endfunction

   function automatic logic [hrof_pkg::RATE_W-1:0] round_mean(
      input logic [hrof_pkg::RATE_W-1:0] a, b);
      logic [hrof_pkg::RATE_W:0] s;
      s = {1'b0, a} + {1'b0, b} + 9'd1;
      return s[hrof_pkg::RATE_W:1];
   endfunction

   function automatic logic [hrof_pkg::RATE_W-1:0] middle_of(
      input logic [hrof_pkg::RATE_W-1:0] a, b, c);
      logic [hrof_pkg::RATE_W-1:0] lo, hi;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      if (c <= lo) return lo;
      if (c >= hi) return hi;
      return c;
   endfunction

   function automatic int clamp_rate(input int v);
      return v < 0 ? 0 : (v > 255 ? 255 : v);
   endfunction

   function automatic logic [hrof_pkg::RATE_W-1:0] smooth_rate(
      input logic [hrof_pkg::RATE_W-1:0] v);
      logic [1:0] p;
      p = hist_pos < 3 ? hist_pos : 2'd0;
      hist[p] = v;
      hist_pos = p == 2 ? 2'd0 : p + 2'd1;
      if (hist_fill < 3) hist_fill++;
      if (hist_fill == 1) return hist[0];
      if (hist_fill == 2) return round_mean(hist[0], hist[1]);
      return middle_of(hist[0], hist[1], hist[2]);
   endfunction

   function automatic void note_agreement(input logic [hrof_pkg::RATE_W-1:0] f);
      if (cand_cnt != 8'hFF) cand_cnt++;
      cand_rate = round_mean(cand_rate, f);
   endfunction

   function automatic void take_rate(input logic [hrof_pkg::RATE_W-1:0] tgt);
      shown_rate = limit_step(shown_rate, tgt, cfg.step_cap);
      cur_status = hrof_pkg::STATUS_OK;
      cand_rate = shown_rate;
      cand_cnt = '0;
   endfunction

   function automatic rate_word_type filter_rate(input logic vld,
                                                 input logic [hrof_pkg::RATE_W-1:0] raw);
      rate_word_type               w;
      logic [hrof_pkg::RATE_W-1:0] f, d, need, tgt;
      logic                        spike, clr;
      clr = 1'b0;
      if (vld) begin
         f = smooth_rate(raw);
         miss_cnt = '0;
         if (!is_locked) begin
            if (cand_cnt == 0 || rate_gap(f, cand_rate) > cfg.small_delta) begin
               cand_rate = f;
               cand_cnt = 8'd1;
            end else begin
               note_agreement(f);
            end
            if (cand_cnt >= cfg.start_confirm) begin
               is_locked = 1'b1;
               shown_rate = cand_rate;
               cur_status = hrof_pkg::STATUS_OK;
               cand_cnt = '0;
            end
         end else begin
            d = rate_gap(f, shown_rate);
            if (d <= cfg.small_delta) begin
               take_rate(8'((int'(shown_rate) * 3 + int'(f) + 2) / 4));
            end else begin
               spike = d > cfg.spike_delta;
               need = spike ? cfg.spike_confirm : cfg.medium_confirm;
               if (cand_cnt == 0 || rate_gap(f, cand_rate) > cfg.match_delta) begin
                  cand_rate = f;
                  cand_cnt = 8'd1;
               end else begin
                  note_agreement(f);
                  if (cand_cnt >= need) begin
                     tgt = spike ? 8'((int'(shown_rate) * 5 + int'(cand_rate) * 3 + 4) / 8)
                                 : round_mean(shown_rate, cand_rate);
                     take_rate(tgt);
                  end
               end
            end
         end
      end else if (is_locked && miss_cnt < cfg.hold_ticks) begin
         miss_cnt++;
      end else begin
         foreach (hist[i]) hist[i] = '0;
         hist_fill = '0;
         hist_pos = '0;
         cand_rate = '0;
         cand_cnt = '0;
         miss_cnt = '0;
         shown_rate = '0;
         is_locked = 1'b0;
         cur_status = hrof_pkg::STATUS_STALE;
         clr = 1'b1;
      end
      w.rate = shown_rate;
      w.locked = is_locked;
      w.status = cur_status;
      w.cleared = clr;
      return w;
   endfunction

   task automatic send_word(input logic vld, input logic [hrof_pkg::RATE_W-1:0] raw,
                            input logic known, input rate_word_type want);
      int            gap;
      rate_word_type predicted;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_valid <= vld;
      req_raw_rate <= raw;
      do @(posedge clock); while (req_stall);
      predicted = filter_rate(vld, raw);
      rate_words.push_back(known ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (rate_words.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input hrof_pkg::csr_index_type idx,
                            input logic [hrof_pkg::CFG_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      case (idx)
         hrof_pkg::CSR_SMALL_DELTA: cfg.small_delta = val;
         hrof_pkg::CSR_MATCH_DELTA: cfg.match_delta = val;
         hrof_pkg::CSR_SPIKE_DELTA: cfg.spike_delta = val;
         hrof_pkg::CSR_START_CONF:  cfg.start_confirm = val;
         hrof_pkg::CSR_MEDIUM_CONF: cfg.medium_confirm = val;
         hrof_pkg::CSR_SPIKE_CONF:  cfg.spike_confirm = val;
         hrof_pkg::CSR_HOLD_TICKS:  cfg.hold_ticks = val;
         hrof_pkg::CSR_STEP_CAP:    cfg.step_cap = val;
      endcase
   endtask

   task automatic run_phase(input int count, input bit clean);
      int           base, left, jit, v, n;
      run_kind_type kind;
      logic         vld;
      logic [7:0]   raw;
      base = $urandom_range(40, 220);
      left = 0;
      jit = 0;
      kind = RUN_STEADY;
      for (n = 0; n < count; n++) begin
         if (left == 0) begin
            v = clean ? 0 : $urandom_range(0, 19);
            kind = v < 11 ? RUN_STEADY : (v < 15 ? RUN_JUMP : (v < 17 ? RUN_DROP : RUN_NOISE));
            left = $urandom_range(4, 16);
            jit = $urandom_range(0, 6);
            if (kind == RUN_JUMP) begin
               v = $urandom_range(5, 90);
               base = clamp_rate($urandom_range(0, 1) ? base + v : base - v);
            end
            if (kind == RUN_DROP)
               left = $urandom_range(0, 1) ? $urandom_range(1, 3)
                                           : int'(cfg.hold_ticks) + $urandom_range(1, 2);
            calm = ($urandom_range(0, 5) == 0);
         end
         left--;
         case (kind)
            RUN_DROP: begin
               vld = 1'b0;
               raw = 8'($urandom);
            end
            RUN_NOISE: begin
               vld = ($urandom_range(0, 4) != 0);
               raw = 8'($urandom);
            end
            default: begin
               vld = 1'b1;
               raw = 8'(clamp_rate(base + $urandom_range(0, 2 * jit) - jit));
               base = clamp_rate(base + $urandom_range(0, 2) - 1);
            end
         endcase
         send_word(vld, raw, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         fail_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : rsp_check
      rate_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rate_words.size() == 0) begin
            $display("%0t: result word with nothing pending: rate %0d locked %0d status %0d",
                     $time, rsp_rate_out, rsp_rate_locked, rsp_status);
            fail_count++;
         end else begin
            want = rate_words.pop_front();
            check_field("rate_out", want.rate, rsp_rate_out);
            check_field("rate_locked", want.locked, rsp_rate_locked);
            check_field("status", want.status, rsp_status);
            check_field("cleared", want.cleared, rsp_cleared);
            words_checked++;
            if (rsp_cleared) clear_words++;
            if (rsp_rate_locked) locked_words++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("heart_rate_output_filter_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_side
      int n;
      rsp_stall <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         n = calm ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      hrof_pkg::cfg_type settings;
      int                ph;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_raw_valid <= 1'b0;
      req_raw_rate <= '0;
      csr_write <= 1'b0;
      csr_index <= hrof_pkg::CSR_SMALL_DELTA;
      csr_wdata <= '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i])
         send_word(DIR_ROWS[i].vld, DIR_ROWS[i].raw, DIR_ROWS[i].known, DIR_ROWS[i].want);

      for (ph = 0; ph < FIXED_PHASES + RANDOM_PHASES; ph++) begin
         drain_words();
         if (ph < FIXED_PHASES) begin
            settings = PHASE_CFG[ph];
         end else begin
            settings.small_delta = 8'($urandom_range(0, 40));
            settings.match_delta = 8'($urandom_range(0, 60));
            settings.spike_delta = 8'($urandom_range(0, 80));
            settings.start_confirm = 8'($urandom_range(0, 6));
            settings.medium_confirm = 8'($urandom_range(0, 6));
            settings.spike_confirm = 8'($urandom_range(0, 6));
            settings.hold_ticks = 8'($urandom_range(0, 20));
            settings.step_cap = 8'($urandom_range(0, 40));
         end
         write_csr(hrof_pkg::CSR_SMALL_DELTA, settings.small_delta);
         write_csr(hrof_pkg::CSR_MATCH_DELTA, settings.match_delta);
         write_csr(hrof_pkg::CSR_SPIKE_DELTA, settings.spike_delta);
         write_csr(hrof_pkg::CSR_START_CONF, settings.start_confirm);
         write_csr(hrof_pkg::CSR_MEDIUM_CONF, settings.medium_confirm);
         write_csr(hrof_pkg::CSR_SPIKE_CONF, settings.spike_confirm);
         write_csr(hrof_pkg::CSR_HOLD_TICKS, settings.hold_ticks);
         write_csr(hrof_pkg::CSR_STEP_CAP, settings.step_cap);
         csr_write <= 1'b0;
         if (ph < FIXED_PHASES)
            run_phase(PHASE_LEN[ph], PHASE_CLEAN[ph]);
         else
            run_phase(170, 1'b0);
      end

      drain_words();
      repeat (8) @(negedge clock);
      $display("run covered %0d input words over %0d register settings plus the reset defaults",
               items_sent, FIXED_PHASES + RANDOM_PHASES);
      $display("%0d results checked, %0d while locked, %0d filter clears, %0d mismatches",
               words_checked, locked_words, clear_words, fail_count);
      if (fail_count == 0)
         $display("heart_rate_output_filter_core verification clean");
      else
         $display("heart_rate_output_filter_core verification failed");
      $finish;
   end

endmodule
